[hw/rtl/csvtok_pkg.sv]
package csvtok_pkg;

   localparam int COL_W      = 6;
   localparam int OUT_COL_W  = 5;
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   localparam logic [7:0] QUOTE_CHAR = 8'h22;
   localparam logic [7:0] COMMA_CHAR = 8'h2C;

   localparam logic KIND_DATA      = 1'b0;
   localparam logic KIND_FIELD_END = 1'b1;

   typedef struct packed {
      logic [7:0] char_code;
      logic       line_end;
   } req_item_type;

   typedef struct packed {
      logic                 kind;
      logic [7:0]           data_byte;
      logic [OUT_COL_W-1:0] column;
      logic                 is_header;
      logic                 row_end;
      logic                 last;
   } rsp_item_type;

   // work left by one accepted item for the back end
   typedef struct packed {
      logic             hdr;
      logic [7:0]       char_code;
      logic             do_data;
      logic             do_comma;
      logic             comma_end;
      logic [COL_W-1:0] col;
      logic             do_pad;
      logic [COL_W-1:0] pad_col;
      logic [COL_W-1:0] lim;
   } cmd_type;

   typedef enum logic [1:0] {
      PH_DATA,
      PH_COMMA,
      PH_PAD
   } phase_type;

endpackage

[hw/rtl/csvtok_front.sv]
module csvtok_front import csvtok_pkg::*; #(
   parameter int MAX_COLUMNS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_item_type item,
   output logic         cmd_push,
   output cmd_type      cmd
);

   localparam logic [COL_W-1:0] MAX_LIM = COL_W'(MAX_COLUMNS);

   logic             in_quotes_ff, in_quotes_in;
   logic             quote_pending_ff, quote_pending_in;
   logic             field_empty_ff, field_empty_in;
   logic [COL_W-1:0] column_index_ff, column_index_in;
   logic [COL_W-1:0] header_count_ff, header_count_in;
   logic             header_done_ff, header_done_in;

   logic [7:0]       c;
   logic             le;
   logic [COL_W-1:0] lim;
   logic             plain, append, comma, col_ok;
   logic [COL_W-1:0] col_after;
   logic             do_data, do_comma, do_pad;
   logic             iq_mid, qp_mid, fe_mid;

   always_comb begin
      c      = item.char_code;
      le     = item.line_end;
      lim    = header_done_ff ? header_count_ff : MAX_LIM;
      plain  = 1'b0;
      append = 1'b0;
      comma  = 1'b0;
      iq_mid = in_quotes_ff;
      qp_mid = quote_pending_ff;

      if (quote_pending_ff) begin
         qp_mid = 1'b0;
         if (c == QUOTE_CHAR) begin
            append = 1'b1;
         end else begin
            iq_mid = 1'b0;
            plain  = 1'b1;
         end
      end else if (in_quotes_ff) begin
         if (c == QUOTE_CHAR) begin
            qp_mid = 1'b1;
         end else begin
            append = 1'b1;
         end
      end else begin
         plain = 1'b1;
      end

      if (plain) begin
         if (c == COMMA_CHAR) begin
            comma = 1'b1;
         end else if (c == QUOTE_CHAR && field_empty_ff) begin
            iq_mid = 1'b1;
         end else begin
            append = 1'b1;
         end
      end

      fe_mid = field_empty_ff;
      if (append) begin
         fe_mid = 1'b0;
      end
      if (comma) begin
         fe_mid = 1'b1;
      end

      col_ok    = column_index_ff < lim;
      do_data   = append && col_ok;
      do_comma  = comma && col_ok;
      col_after = do_comma ? column_index_ff + COL_W'(1) : column_index_ff;
      do_pad    = le && (col_after < lim);
   end

   always_comb begin
      in_quotes_in     = in_quotes_ff;
      quote_pending_in = quote_pending_ff;
      field_empty_in   = field_empty_ff;
      column_index_in  = column_index_ff;
      header_count_in  = header_count_ff;
      header_done_in   = header_done_ff;
      if (accept) begin
         in_quotes_in     = iq_mid;
         quote_pending_in = qp_mid;
         field_empty_in   = fe_mid;
         column_index_in  = col_after;
         if (le) begin
            if (!header_done_ff) begin
               header_count_in = do_pad ? col_after + COL_W'(1) : lim;
            end
            header_done_in   = 1'b1;
            column_index_in  = '0;
            in_quotes_in     = 1'b0;
            quote_pending_in = 1'b0;
            field_empty_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff     <= 1'b0;
         quote_pending_ff <= 1'b0;
         field_empty_ff   <= 1'b1;
         column_index_ff  <= '0;
         header_count_ff  <= '0;
         header_done_ff   <= 1'b0;
      end else begin
         in_quotes_ff     <= in_quotes_in;
         quote_pending_ff <= quote_pending_in;
         field_empty_ff   <= field_empty_in;
         column_index_ff  <= column_index_in;
         header_count_ff  <= header_count_in;
         header_done_ff   <= header_done_in;
      end
   end

   always_comb begin
      cmd_push      = accept && (do_data || do_comma || do_pad);
      cmd.hdr       = !header_done_ff;
      cmd.char_code = c;
      cmd.do_data   = do_data;
      cmd.do_comma  = do_comma;
      cmd.comma_end = (column_index_ff + COL_W'(1)) == lim;
      cmd.col       = column_index_ff;
      cmd.do_pad    = do_pad;
      cmd.pad_col   = col_after;
      cmd.lim       = lim;
   end

   a_col_in_limit: assert property (@(posedge clock) disable iff (reset)
      column_index_ff <= lim)
      else $error("column index beyond column limit");

   a_header_nonzero: assert property (@(posedge clock) disable iff (reset)
      header_done_ff |-> (header_count_ff != '0))
      else $error("header done with zero columns");

endmodule

[hw/rtl/csvtok_cmdq.sv]
module csvtok_cmdq import csvtok_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_cmd,
   output logic    full,
   input  logic    rd_en,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type                slot_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]  count_ff, count_in;
   logic                   do_wr, do_rd;

   always_comb begin
      full       = count_ff == CMDQ_CNT_W'(CMDQ_DEPTH);
      head_valid = count_ff != '0;
      head_cmd   = slot_ff[rd_ptr_ff];
      do_wr      = wr_en && !full;
      do_rd      = rd_en && head_valid;
      wr_ptr_in  = do_wr ? wr_ptr_ff + CMDQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = do_rd ? rd_ptr_ff + CMDQ_PTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + CMDQ_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CMDQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CMDQ_CNT_W'(CMDQ_DEPTH))
      else $error("command queue over-filled");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("command queue pointers disagree with count");

endmodule

[hw/rtl/csvtok_back.sv]
module csvtok_back import csvtok_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  cmd_type      head_cmd,
   output logic         head_pop,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_item
);

   phase_type        phase_ff, phase_in;
   logic [COL_W-1:0] pad_k_ff, pad_k_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   logic             out_ready, fire;
   logic             cur_data, cur_comma;
   logic [COL_W-1:0] k;
   logic             item_last;

   // pick the first piece of work still owed by the head command
   always_comb begin
      out_ready = !rsp_valid_ff || pop;
      fire      = head_valid && out_ready;
      cur_data  = (phase_ff == PH_DATA) && head_cmd.do_data;
      cur_comma = !cur_data && (phase_ff != PH_PAD) && head_cmd.do_comma;
      k         = (phase_ff == PH_PAD) ? pad_k_ff : head_cmd.pad_col;
      if (cur_data) begin
         item_last = !head_cmd.do_comma && !head_cmd.do_pad;
      end else if (cur_comma) begin
         item_last = !head_cmd.do_pad;
      end else begin
         item_last = (k + COL_W'(1)) == head_cmd.lim;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      pad_k_in = pad_k_ff;
      if (fire) begin
         if (item_last) begin
            phase_in = PH_DATA;
         end else if (cur_data) begin
            phase_in = PH_COMMA;
         end else if (cur_comma) begin
            phase_in = PH_PAD;
            pad_k_in = head_cmd.pad_col;
         end else begin
            phase_in = PH_PAD;
            pad_k_in = k + COL_W'(1);
         end
      end
   end

   always_comb begin
      head_pop              = fire && item_last;
      rsp_item_in.is_header = head_cmd.hdr;
      rsp_item_in.last      = item_last;
      if (cur_data) begin
         rsp_item_in.kind      = KIND_DATA;
         rsp_item_in.data_byte = head_cmd.char_code;
         rsp_item_in.column    = head_cmd.col[OUT_COL_W-1:0];
         rsp_item_in.row_end   = 1'b0;
      end else if (cur_comma) begin
         rsp_item_in.kind      = KIND_FIELD_END;
         rsp_item_in.data_byte = '0;
         rsp_item_in.column    = head_cmd.col[OUT_COL_W-1:0];
         rsp_item_in.row_end   = head_cmd.comma_end;
      end else begin
         rsp_item_in.kind      = KIND_FIELD_END;
         rsp_item_in.data_byte = '0;
         rsp_item_in.column    = k[OUT_COL_W-1:0];
         rsp_item_in.row_end   = item_last;
      end
      rsp_valid_in = fire ? 1'b1 : (pop ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DATA;
         pad_k_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pad_k_ff     <= pad_k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

   a_pad_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAD && head_valid) |-> (pad_k_ff < head_cmd.lim))
      else $error("padding column beyond column limit");

   a_phase_has_head: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_DATA) |-> head_valid)
      else $error("mid-command phase with no command at head");

endmodule

[hw/rtl/csv_row_field_tokenizer_core.sv]
// channel   ports                         handshake
// input     req_item, push, full          taken when push & !full
// result    rsp_item, empty, pop          taken when pop & !empty
//
// one input item is taken per cycle while the four-entry command queue has room
// the back end emits one result per cycle unless pop stalls, one item at a time
// a row-end item emits up to MAX_COLUMNS results from the padding counter
// an item's work passes the command queue, then the result register, to the ports
// reset clears quote state, column counters, the command queue and the result valid flag
// a stalled pop holds the back end, which fills the queue and then raises full
module csv_row_field_tokenizer_core import csvtok_pkg::*; #(
   parameter int MAX_COLUMNS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_item_type req_item,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_item
);

   logic    accept;
   logic    cmd_push;
   cmd_type cmd;
   logic    head_valid;
   logic    head_pop;
   cmd_type head_cmd;

   assign accept = push && !full;

   csvtok_front #(
      .MAX_COLUMNS(MAX_COLUMNS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .item    (req_item),
      .cmd_push(cmd_push),
      .cmd     (cmd)
   );

   csvtok_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (cmd_push),
      .wr_cmd    (cmd),
      .full      (full),
      .rd_en     (head_pop),
      .head_valid(head_valid),
      .head_cmd  (head_cmd)
   );

   csvtok_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_cmd  (head_cmd),
      .head_pop  (head_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item)
   );

endmodule

[bench/tb_csv_row_field_tokenizer_core.sv]
`timescale 1ns / 100ps

module tb_csv_row_field_tokenizer_core;
   import csvtok_pkg::*;

   localparam int MAX_COLS      = 32;
   localparam int RANDOM_ITEMS  = 180;
   localparam int NO_IDLE_ITEMS = 60;
   localparam int HOLD_CYCLES   = 150;
   localparam int DRAIN_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 200000;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         push     = 1'b0;
   logic         pop      = 1'b0;
   req_item_type req_item = '0;
   logic         full;
   logic         empty;
   rsp_item_type rsp_item;

   // predicted tokenizer state
   logic       quoted_now;
   logic       quote_seen;
   logic       field_blank;
   logic [5:0] cur_column;
   logic [5:0] row_width;
   logic       header_seen;

   rsp_item_type expected_tokens[$];
   logic [7:0]   line_buf[$];

   int  fail_count  = 0;
   int  sent_count  = 0;
   int  cycle_count = 0;
   int  hold_token  = 0;
   int  hold_seen   = 0;
   int  hold_left   = 0;
   bit  no_idle     = 1'b0;

   csv_row_field_tokenizer_core #(
      .MAX_COLUMNS(MAX_COLS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic rsp_item_type make_token(input logic kind, input logic [7:0] data,
                                               input logic [5:0] col, input logic hdr,
                                               input logic rend);
      rsp_item_type tok;
      tok.kind      = kind;
      tok.data_byte = data;
      tok.column    = col[OUT_COL_W-1:0];
      tok.is_header = hdr;
      tok.row_end   = rend;
      tok.last      = 1'b0;
      return tok;
   endfunction

   task automatic clear_prediction();
      quoted_now  = 1'b0;
      quote_seen  = 1'b0;
      field_blank = 1'b1;
      cur_column  = '0;
      row_width   = '0;
      header_seen = 1'b0;
      expected_tokens.delete();
   endtask

   task automatic predict_tokens(input req_item_type item);
      rsp_item_type toks[$];
      logic [5:0]   lim;
      logic         hdr;
      logic         plain;
      logic         add_byte;
      logic         sep;
      int           k;
      plain    = 1'b0;
      add_byte = 1'b0;
      sep      = 1'b0;
      lim      = header_seen ? row_width : 6'(MAX_COLS);
      hdr      = !header_seen;

      if (quote_seen) begin
         quote_seen = 1'b0;
         // doubled quote inside quotes gives one literal quote
         if (item.char_code == QUOTE_CHAR) begin
            add_byte = 1'b1;
         end else begin
            quoted_now = 1'b0;
            plain      = 1'b1;
         end
      end else if (quoted_now) begin
         if (item.char_code == QUOTE_CHAR) quote_seen = 1'b1;
         else add_byte = 1'b1;
      end else begin
         plain = 1'b1;
      end

      if (plain) begin
         if (item.char_code == COMMA_CHAR) sep = 1'b1;
         else if (item.char_code == QUOTE_CHAR && field_blank) quoted_now = 1'b1;
         else add_byte = 1'b1;
      end

      if (add_byte) begin
         field_blank = 1'b0;
         if (cur_column < lim)
            toks.push_back(make_token(KIND_DATA, item.char_code, cur_column, hdr, 1'b0));
      end
      if (sep) begin
         if (cur_column < lim) begin
            toks.push_back(make_token(KIND_FIELD_END, 8'h00, cur_column, hdr,
                                      cur_column + 1 == lim));
            cur_column++;
         end
         field_blank = 1'b1;
      end

      if (item.line_end) begin
         if (cur_column < lim) begin
            // current field end, then padding up to the column count
            for (k = cur_column; k < lim; k++)
               toks.push_back(make_token(KIND_FIELD_END, 8'h00, 6'(k), hdr, k + 1 == lim));
            if (!header_seen) row_width = cur_column + 6'd1;
         end else if (!header_seen) begin
            row_width = lim;
         end
         header_seen = 1'b1;
         cur_column  = '0;
         quoted_now  = 1'b0;
         quote_seen  = 1'b0;
         field_blank = 1'b1;
      end

      if (toks.size() > 0) toks[toks.size()-1].last = 1'b1;
      foreach (toks[i]) expected_tokens.push_back(toks[i]);
   endtask

   function automatic int field_mismatch(input string name, input logic [7:0] exp_v,
                                         input logic [7:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
         return 1;
      end
      return 0;
   endfunction

   task automatic check_token(input rsp_item_type got);
      rsp_item_type want;
      int           bad;
      if (expected_tokens.size() == 0) begin
         $error("unexpected result: kind %0d data 0x%0h column %0d", got.kind,
                got.data_byte, got.column);
         fail_count++;
      end else begin
         want = expected_tokens.pop_front();
         bad  = field_mismatch("kind", 8'(want.kind), 8'(got.kind));
         bad += field_mismatch("data_byte", want.data_byte, got.data_byte);
         bad += field_mismatch("column", 8'(want.column), 8'(got.column));
         bad += field_mismatch("is_header", 8'(want.is_header), 8'(got.is_header));
         bad += field_mismatch("row_end", 8'(want.row_end), 8'(got.row_end));
         bad += field_mismatch("last", 8'(want.last), 8'(got.last));
         fail_count += bad;
      end
   endtask

   // result side: checks each taken item, idles at random, honours hold requests
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) check_token(rsp_item);
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (no_idle) begin
            pop <= 1'b1;
         end else begin
            pop <= ($urandom_range(99) >= 35);
         end
      end
   end

   task automatic send_item(input logic [7:0] code, input logic eol);
      // each idle cycle is drawn on its own so about a third of cycles idle
      while (!no_idle && $urandom_range(99) < 35) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_item <= '{char_code: code, line_end: eol};
      @(posedge clock);
      while (full) @(posedge clock);
      predict_tokens(req_item);
      sent_count++;
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_item(line_buf[i], i == line_buf.size() - 1);
   endtask

   task automatic send_text(input string s);
      line_buf.delete();
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
      send_line();
   endtask

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b == QUOTE_CHAR || b == COMMA_CHAR);
      return b;
   endfunction

   task automatic fill_random_row();
      int nfields;
      int pick;
      int nbytes;
      line_buf.delete();
      nfields = ($urandom_range(99) < 12) ? $urandom_range(30, 36) : $urandom_range(1, 6);
      for (int f = 0; f < nfields; f++) begin
         if (f > 0) line_buf.push_back(COMMA_CHAR);
         pick   = $urandom_range(99);
         nbytes = (nfields > 20) ? $urandom_range(0, 1) : $urandom_range(0, 3);
         if (pick < 40) begin
            repeat (nbytes) line_buf.push_back(text_byte());
         end else if (pick < 65) begin
            line_buf.push_back(QUOTE_CHAR);
            repeat (nbytes) begin
               case ($urandom_range(3))
                  0: line_buf.push_back(COMMA_CHAR);
                  1: begin
                     line_buf.push_back(QUOTE_CHAR);
                     line_buf.push_back(QUOTE_CHAR);
                  end
                  default: line_buf.push_back(text_byte());
               endcase
            end
            // now and then leave the quote open or trail plain text
            if ($urandom_range(9) != 0) line_buf.push_back(QUOTE_CHAR);
            if ($urandom_range(9) == 0) line_buf.push_back(text_byte());
         end else if (pick < 80) begin
            // empty field
         end else begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(255)));
         end
      end
      if (line_buf.size() == 0) line_buf.push_back(8'($urandom_range(255)));
   endtask

   // header wider than the limit: surplus fields dropped, count saturates
   task automatic test_long_header();
      line_buf.delete();
      line_buf.push_back("h");
      repeat (MAX_COLS + 1) line_buf.push_back(COMMA_CHAR);
      line_buf.push_back("z");
      send_line();
   endtask

   task automatic test_quoting();
      send_text("\"a\"\"b\",c");
      send_text("\"x\"y,\"q");
      send_text("a\",\"\"");
      line_buf.delete();
      line_buf.push_back(8'h00);
      line_buf.push_back(8'hFF);
      send_line();
   endtask

   task automatic test_output_stall();
      hold_token++;
      send_text("p,q,r,s,t,u,v,w,x,y,z");
   endtask

   task automatic test_random_rows();
      int start;
      start   = sent_count;
      no_idle = 1'b1;
      while (sent_count - start < RANDOM_ITEMS) begin
         if (sent_count - start >= NO_IDLE_ITEMS) no_idle = 1'b0;
         fill_random_row();
         send_line();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      clear_prediction();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_long_header();
      test_quoting();
      test_output_stall();
      test_random_rows();

      push <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_tokens.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[csv_row_field_tokenizer_core.f]
hw/rtl/csvtok_pkg.sv
hw/rtl/csvtok_front.sv
hw/rtl/csvtok_cmdq.sv
hw/rtl/csvtok_back.sv
hw/rtl/csv_row_field_tokenizer_core.sv
bench/tb_csv_row_field_tokenizer_core.sv
